[hdl/isl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

  // List geometry
  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int POS_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Transaction field widths
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Wide enough to compare an index against the count without wrap
  localparam int CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

  // tdata layout, lowest field first, padded to whole bytes
  localparam int IN_MODE_LSB    = 0;
  localparam int IN_INDEX_LSB   = IN_MODE_LSB + MODE_W;
  localparam int IN_VALUE_LSB   = IN_INDEX_LSB + INDEX_W;
  localparam int IN_USED_W      = IN_VALUE_LSB + VALUE_W;
  localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_REMOVED_LSB = 0;
  localparam int OUT_STATUS_LSB  = OUT_REMOVED_LSB + VALUE_W;
  localparam int OUT_COUNT_LSB   = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_USED_W      = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_USED_W;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [INDEX_W-1:0]    index_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [COUNT_W-1:0]    count_field_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 3'd0,
    MODE_REMOVE     = 3'd1,
    MODE_PUSH_BACK  = 3'd2,
    MODE_PUSH_FRONT = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_POP_FRONT  = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast from the control to the cell row
  typedef struct packed {
    logic ins;
    logic rem;
    pos_t pos;
  } list_op_t;

  // Per-cell load selection
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/indexed_shift_list_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result: registered, valid on out_tvalid in the cycle after the input transaction.
// Throughput: one operation per cycle while out_tready drains the output; the row
// of cells shifts up or down one place at once; one output register holds the result.
// Reset: entry count cleared, output register empty and in_tready low; cell
// words are not reset and are only read below the count.

module indexed_shift_list_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // in_tdata: mode[2:0], item_index[7:3], item_value[39:8]
  input  wire logic [isl_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_tdata: removed_value[31:0], status[33:32], entry_count[38:34], pad[39]
  output logic [isl_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  logic                    in_fire;
  isl_pkg::mode_t          mode;
  isl_pkg::index_t         item_index;
  isl_pkg::value_t         item_value;
  isl_pkg::word_t          new_word;
  isl_pkg::list_op_t       op;
  isl_pkg::status_t        status;
  isl_pkg::cnt_t           count_nxt;
  isl_pkg::word_t          cells_q [isl_pkg::CAPACITY];
  isl_pkg::cell_ctl_t      cell_ctl [isl_pkg::CAPACITY];
  isl_pkg::value_t         removed;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  isl_pkg::value_t         removed_r;
  isl_pkg::status_t        status_r;
  isl_pkg::count_field_t   count_out_r;

  // Input unpack
  assign mode       = isl_pkg::mode_t'(in_tdata[isl_pkg::IN_INDEX_LSB-1:isl_pkg::IN_MODE_LSB]);
  assign item_index = in_tdata[isl_pkg::IN_VALUE_LSB-1:isl_pkg::IN_INDEX_LSB];
  assign item_value = in_tdata[isl_pkg::IN_USED_W-1:isl_pkg::IN_VALUE_LSB];
  assign new_word   = isl_pkg::word_t'(item_value);

  // Accept out of reset while the output register is empty or being drained
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  isl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .mode       (mode),
    .item_index (item_index),
    .op         (op),
    .status     (status),
    .count_nxt  (count_nxt)
  );

  // Row of cells; each loads from its neighbors under a per-cell select
  for (genvar i = 0; i < isl_pkg::CAPACITY; i++) begin : g_cell
    isl_pkg::word_t left_d;
    isl_pkg::word_t right_d;

    always_comb begin
      cell_ctl[i].load       = op.ins && (op.pos == isl_pkg::pos_t'(i));
      cell_ctl[i].take_left  = op.ins && (op.pos <  isl_pkg::pos_t'(i));
      cell_ctl[i].take_right = op.rem && (op.pos <= isl_pkg::pos_t'(i))
                               && (i < isl_pkg::CAPACITY - 1);
    end

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cells_q[i-1];
    end

    if (i == isl_pkg::CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cells_q[i+1];
    end

    isl_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_value  (new_word),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cells_q[i])
    );
  end

  // Word leaving the list, taken before the row shifts
  assign removed = op.rem ? isl_pkg::value_t'(cells_q[op.pos]) : '0;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      removed_r   <= removed;
      status_r    <= status;
      count_out_r <= isl_pkg::count_field_t'(count_nxt);
    end
  end

  // Output pack
  assign out_tvalid = out_valid_r;
  assign out_tdata[isl_pkg::OUT_STATUS_LSB-1:isl_pkg::OUT_REMOVED_LSB] = removed_r;
  assign out_tdata[isl_pkg::OUT_COUNT_LSB-1:isl_pkg::OUT_STATUS_LSB]   = status_r;
  assign out_tdata[isl_pkg::OUT_USED_W-1:isl_pkg::OUT_COUNT_LSB]       = count_out_r;
  assign out_tdata[isl_pkg::OUT_TDATA_W-1:isl_pkg::OUT_USED_W]         = '0;

endmodule

`default_nettype wire

[hdl/isl_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module isl_cell (
  input  wire logic              clk,
  input  wire isl_pkg::cell_ctl_t ctl,
  input  wire isl_pkg::word_t    new_value,
  input  wire isl_pkg::word_t    left_data,
  input  wire isl_pkg::word_t    right_data,
  output isl_pkg::word_t         data_q
);

  isl_pkg::word_t data_r;
  isl_pkg::word_t data_nxt;

  // Pick the new word: fresh value, neighbor below, neighbor above, or hold
  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = new_value;
    end else if (ctl.take_left) begin
      data_nxt = left_data;
    end else if (ctl.take_right) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

[hdl/isl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module isl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire isl_pkg::mode_t    mode,
  input  wire isl_pkg::index_t   item_index,
  output isl_pkg::list_op_t      op,
  output isl_pkg::status_t       status,
  output isl_pkg::cnt_t          count_nxt
);

  isl_pkg::cnt_t    count_r;
  isl_pkg::cmp_t    cnt_ext;
  isl_pkg::cmp_t    tgt;
  logic             ins_req;
  logic             rem_req;
  logic             ins_ok;
  logic             rem_ok;

  assign cnt_ext = isl_pkg::cmp_t'(count_r);

  // Decode the operation and its target position
  always_comb begin
    ins_req = 1'b0;
    rem_req = 1'b0;
    tgt     = '0;
    case (mode)
      isl_pkg::MODE_INSERT: begin
        ins_req = 1'b1;
        tgt     = isl_pkg::cmp_t'(item_index);
      end
      isl_pkg::MODE_REMOVE: begin
        rem_req = 1'b1;
        tgt     = isl_pkg::cmp_t'(item_index);
      end
      isl_pkg::MODE_PUSH_BACK: begin
        ins_req = 1'b1;
        tgt     = cnt_ext;
      end
      isl_pkg::MODE_PUSH_FRONT: begin
        ins_req = 1'b1;
      end
      isl_pkg::MODE_POP_BACK: begin
        rem_req = 1'b1;
        tgt     = cnt_ext - isl_pkg::cmp_t'(1);
      end
      isl_pkg::MODE_POP_FRONT: begin
        rem_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Status: full before range on inserts, empty before range on removes
  always_comb begin
    status = isl_pkg::ST_OK;
    if (ins_req) begin
      if (count_r == isl_pkg::cnt_t'(isl_pkg::CAPACITY)) begin
        status = isl_pkg::ST_FULL;
      end else if (tgt > cnt_ext) begin
        status = isl_pkg::ST_RANGE;
      end
    end else if (rem_req) begin
      if (count_r == '0) begin
        status = isl_pkg::ST_EMPTY;
      end else if (tgt >= cnt_ext) begin
        status = isl_pkg::ST_RANGE;
      end
    end
  end

  assign ins_ok = ins_req && (status == isl_pkg::ST_OK);
  assign rem_ok = rem_req && (status == isl_pkg::ST_OK);

  // Count after this transaction and the command to the cell row
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + isl_pkg::cnt_t'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - isl_pkg::cnt_t'(1);
    end
    op.ins = fire && ins_ok;
    op.rem = fire && rem_ok;
    op.pos = tgt[isl_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/isl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module isl_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [isl_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [isl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [isl_pkg::STATUS_W-1:0] st;
  logic [isl_pkg::COUNT_W-1:0]  cnt;
  logic [isl_pkg::VALUE_W-1:0]  rmv;

  assign st  = out_tdata[isl_pkg::OUT_COUNT_LSB-1:isl_pkg::OUT_STATUS_LSB];
  assign cnt = out_tdata[isl_pkg::OUT_USED_W-1:isl_pkg::OUT_COUNT_LSB];
  assign rmv = out_tdata[isl_pkg::OUT_STATUS_LSB-1:isl_pkg::OUT_REMOVED_LSB];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted transaction yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction gave no result");

  // Full status only with a full list, empty status only with no entries
  a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (st != isl_pkg::ST_FULL  || cnt == isl_pkg::COUNT_W'(isl_pkg::CAPACITY)) &&
      (st != isl_pkg::ST_EMPTY || (cnt == '0 && rmv == '0)))
    else $error("status disagrees with entry count");

  // Count never exceeds the capacity
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt <= isl_pkg::COUNT_W'(isl_pkg::CAPACITY))
    else $error("entry count beyond capacity");

endmodule

bind indexed_shift_list_core isl_checker u_isl_checker (.*);

`default_nettype wire
